// ===== hw/rtl/rssi_avs_pkg.sv =====
// Shared widths and register codes for the signal-strength averaging and scaling block.
`default_nettype none

package rssi_avs_pkg;

  localparam int VALUE_W     = 10;
  localparam int SOURCE_W    = 3;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTIVE_SOURCE = 2'd0,
    REG_RANGE_LOW     = 2'd1,
    REG_RANGE_HIGH    = 2'd2
  } reg_index_t;

  localparam logic [SOURCE_W-1:0] ACTIVE_SOURCE_RESET = 3'd0;
  localparam logic [VALUE_W-1:0]  RANGE_LOW_RESET     = 10'd0;
  localparam logic [VALUE_W-1:0]  RANGE_HIGH_RESET    = 10'd1023;

endpackage

`default_nettype wire

// ===== hw/rtl/rssi_avs_in_if.sv =====
// Sample channel: valid/ready handshake carrying one signal-strength sample.
`default_nettype none

interface rssi_avs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rssi_avs_pkg::VALUE_W-1:0]     sample_value;
  logic [rssi_avs_pkg::SOURCE_W-1:0]    sample_source;
  logic                                 prefiltered;

  modport source (
    output valid, sample_value, sample_source, prefiltered,
    input  ready
  );

  modport sink (
    input  valid, sample_value, sample_source, prefiltered,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/rssi_avs_out_if.sv =====
// Result channel: valid/ready handshake carrying one scaled signal strength.
`default_nettype none

interface rssi_avs_out_if;
  logic                             valid;
  logic                             ready;
  logic [rssi_avs_pkg::VALUE_W-1:0] strength;

  modport source (
    output valid, strength,
    input  ready
  );

  modport sink (
    input  valid, strength,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/rssi_average_and_scale.sv =====
// Top level of the signal-strength averaging and range scaling block.
`default_nettype none

// Samples whose source code differs from active_source are dropped. A
// matching raw sample updates a WINDOW-entry ring and running sum, and its
// floor mean is mapped from range_low..range_high onto 0..FULL_SCALE; a
// prefiltered sample skips the ring. One item is worked on at a time. Both
// the mean and the scaling go through one shared bit-serial divider that
// produces one quotient bit per cycle, Q_W = max(10, bits of FULL_SCALE)
// bits in all, and the input is not ready again until the result has been
// loaded into the output register. Results out of range skip the second
// division and finish sooner. The ring memory needs no clearing pass: slots
// not yet written since reset are taken as zero.
module rssi_average_and_scale #(
  parameter int WINDOW     = 16,
  parameter int FULL_SCALE = 1023
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     cfg_we,
  input  wire logic [rssi_avs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [rssi_avs_pkg::VALUE_W-1:0]         cfg_data,
  rssi_avs_in_if.sink                                   samples,
  rssi_avs_out_if.source                                result
);

  localparam int VALUE_W  = rssi_avs_pkg::VALUE_W;
  localparam int SOURCE_W = rssi_avs_pkg::SOURCE_W;
  localparam int PTR_W    = $clog2(WINDOW);
  localparam int SUM_W    = $clog2(WINDOW) + VALUE_W;
  localparam int FS_W     = $clog2(FULL_SCALE + 1);
  localparam int Q_W      = (FS_W > VALUE_W) ? FS_W : VALUE_W;
  localparam int DEN_W    = ($clog2(WINDOW + 1) > VALUE_W) ? $clog2(WINDOW + 1) : VALUE_W;
  localparam int PROD_W   = Q_W + DEN_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW - 1);
  localparam logic [SUM_W-1:0] SUM_MAX   = SUM_W'(WINDOW * (2 ** VALUE_W - 1));

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_MEAN  = 7'b0000100,
    S_SWAP  = 7'b0001000,
    S_PREP  = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [SOURCE_W-1:0] active_source;
  logic [VALUE_W-1:0]  range_low;
  logic [VALUE_W-1:0]  range_high;

  logic [PTR_W-1:0]    ptr;
  logic                wrapped;
  logic [SUM_W-1:0]    sum;
  logic [VALUE_W-1:0]  sample_r;
  logic [VALUE_W-1:0]  value;
  logic [VALUE_W-1:0]  lo_s;
  logic [VALUE_W-1:0]  hi_s;
  logic [VALUE_W-1:0]  v_m;
  logic [VALUE_W-1:0]  strength_r;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_strength;

  logic                accept;
  logic                matched;
  logic [VALUE_W-1:0]  ram_rdata;
  logic [VALUE_W-1:0]  old_value;
  logic [SUM_W-1:0]    sum_next;
  logic [PROD_W-1:0]   sum_ext;
  logic                swap;
  logic [VALUE_W-1:0]  lo_sw;
  logic [VALUE_W-1:0]  hi_sw;
  logic [VALUE_W-1:0]  delta;
  logic [VALUE_W-1:0]  v_mir;
  logic [VALUE_W-1:0]  span;
  logic [VALUE_W-1:0]  offset;
  logic [PROD_W-1:0]   product;
  logic                zero_case;
  logic                need_div;

  logic                div_start;
  logic [DEN_W-1:0]    div_rem_init;
  logic [Q_W-1:0]      div_low;
  logic [DEN_W-1:0]    div_divisor;
  logic                div_done;
  logic [Q_W-1:0]      div_quot;

  assign samples.ready   = (state == S_IDLE);
  assign accept          = samples.valid && samples.ready;
  assign matched         = samples.sample_source == active_source;
  assign result.valid    = out_valid;
  assign result.strength = out_strength;

  // Ring slots are written in order from slot zero, so a slot holds data only
  // once the pointer has wrapped at least once.
  assign old_value = wrapped ? ram_rdata : '0;
  assign sum_next  = sum + SUM_W'(sample_r) - SUM_W'(old_value);
  assign sum_ext   = PROD_W'(sum_next);

  // Reversed bounds are swapped and the value mirrored inside them.
  assign swap  = range_low > range_high;
  assign lo_sw = swap ? range_high : range_low;
  assign hi_sw = swap ? range_low : range_high;
  assign delta = (value >= lo_sw) ? value - lo_sw : '0;
  assign v_mir = swap ? ((hi_sw >= delta) ? hi_sw - delta : '0) : value;

  assign span      = hi_s - lo_s;
  assign offset    = v_m - lo_s;
  assign product   = PROD_W'(FULL_SCALE) * PROD_W'(offset);
  assign zero_case = (lo_s == hi_s) || (v_m <= lo_s);
  // At or above the upper bound the quotient is at least FULL_SCALE.
  assign need_div  = !zero_case && (v_m < hi_s);

  // Both dividends are below divisor << Q_W, so their high part seeds the
  // remainder and only Q_W steps are needed.
  assign div_start    = (state == S_READ) || ((state == S_PREP) && need_div);
  assign div_rem_init = (state == S_READ) ? sum_ext[PROD_W-1:Q_W] : product[PROD_W-1:Q_W];
  assign div_low      = (state == S_READ) ? sum_ext[Q_W-1:0] : product[Q_W-1:0];
  assign div_divisor  = (state == S_READ) ? DEN_W'(WINDOW) : DEN_W'(span);

  rssi_avs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_READ),
    .waddr (ptr),
    .wdata (sample_r),
    .re    (state == S_IDLE),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  rssi_avs_div #(
    .Q_W   (Q_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .low_bits (div_low),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_source <= rssi_avs_pkg::ACTIVE_SOURCE_RESET;
      range_low     <= rssi_avs_pkg::RANGE_LOW_RESET;
      range_high    <= rssi_avs_pkg::RANGE_HIGH_RESET;
    end else if (cfg_we) begin
      case (rssi_avs_pkg::reg_index_t'(cfg_index))
        rssi_avs_pkg::REG_ACTIVE_SOURCE: active_source <= cfg_data[SOURCE_W-1:0];
        rssi_avs_pkg::REG_RANGE_LOW:     range_low     <= cfg_data;
        rssi_avs_pkg::REG_RANGE_HIGH:    range_high    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      wrapped   <= 1'b0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result drops out_valid; the output step reloads or holds it.
      if (result.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && matched) begin
            sample_r <= samples.sample_value;
            if (samples.prefiltered) begin
              value <= samples.sample_value;
              state <= S_SWAP;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          sum <= sum_next;
          if (ptr == LAST_SLOT) begin
            ptr     <= '0;
            wrapped <= 1'b1;
          end else begin
            ptr <= ptr + 1'b1;
          end
          state <= S_MEAN;
        end
        S_MEAN: begin
          if (div_done) begin
            value <= div_quot[VALUE_W-1:0];
            state <= S_SWAP;
          end
        end
        S_SWAP: begin
          lo_s  <= lo_sw;
          hi_s  <= hi_sw;
          v_m   <= v_mir;
          state <= S_PREP;
        end
        S_PREP: begin
          if (zero_case) begin
            strength_r <= '0;
            state      <= S_OUT;
          end else if (!need_div) begin
            strength_r <= VALUE_W'(FULL_SCALE);
            state      <= S_OUT;
          end else begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (div_done) begin
            strength_r <= div_quot[VALUE_W-1:0];
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || result.ready) begin
            out_valid    <= 1'b1;
            out_strength <= strength_r;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_drop_no_work: assert property (@(posedge clk) disable iff (rst)
    (accept && !matched) |=> (state == S_IDLE))
    else $error("dropped sample started work");

  a_bypass_skips_ring: assert property (@(posedge clk) disable iff (rst)
    (accept && matched && samples.prefiltered) |=> (state == S_SWAP) && $stable(sum))
    else $error("prefiltered sample touched the ring");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    sum <= SUM_MAX)
    else $error("running sum out of range");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/rssi_avs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rssi_avs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rssi_avs_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module rssi_avs_div #(
  parameter int Q_W   = 10,
  parameter int DEN_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DEN_W-1:0] rem_init,
  input  wire logic [Q_W-1:0]   low_bits,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic      [Q_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

  logic             busy;
  logic [CNT_W-1:0] step;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [Q_W-1:0]   shreg;
  logic [DEN_W:0]   trial;
  logic             fits;

  // The caller guarantees that rem_init is below the divisor, so the quotient
  // fits in Q_W bits and only the low dividend bits need to be shifted in.
  assign trial    = {rem, shreg[Q_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == LAST_STEP);
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        rem   <= rem_init;
        den   <= divisor;
        shreg <= low_bits;
      end else if (busy) begin
        rem   <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        shreg <= {shreg[Q_W-2:0], fits};
        step  <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/rssi_average_and_scale_test.sv =====
// Self-checking testbench for the signal-strength averaging and range scaling block.
`timescale 1ns / 100ps

module rssi_average_and_scale_test;

  localparam int VALUE_W     = rssi_avs_pkg::VALUE_W;
  localparam int SOURCE_W    = rssi_avs_pkg::SOURCE_W;
  localparam int CFG_INDEX_W = rssi_avs_pkg::CFG_INDEX_W;

  typedef enum logic [SOURCE_W-1:0] {
    SRC_NONE       = 3'd0,
    SRC_ADC        = 3'd1,
    SRC_RX_CHANNEL = 3'd2,
    SRC_PROTOCOL   = 3'd3,
    SRC_MSP        = 3'd4
  } source_code_t;

  localparam int          RING_DEPTH    = 16;
  localparam int unsigned STRENGTH_MAX  = 1023;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          STALL_LIMIT   = 1000;
  localparam int          RANDOM_PHASES = 10;
  localparam int          PHASE_ITEMS   = 175;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [VALUE_W-1:0]     cfg_data;

  rssi_avs_in_if  samples_if ();
  rssi_avs_out_if result_if ();

  rssi_average_and_scale u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .result    (result_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the block's registers and averaging state.
  logic [SOURCE_W-1:0] active_src = SRC_NONE;
  logic [VALUE_W-1:0]  range_lo   = rssi_avs_pkg::RANGE_LOW_RESET;
  logic [VALUE_W-1:0]  range_hi   = rssi_avs_pkg::RANGE_HIGH_RESET;
  logic [VALUE_W-1:0]  avg_ring [RING_DEPTH];
  logic [3:0]          avg_slot   = '0;
  logic [13:0]         avg_sum    = '0;

  logic [VALUE_W-1:0] expected_strength [$];
  int                 error_count = 0;

  bit pacing_on  = 1'b1;
  int burst_left = 8;

  function automatic logic [VALUE_W-1:0] scale_strength(logic [VALUE_W-1:0] level);
    int unsigned lo, hi, x, delta, q;
    lo = range_lo;
    hi = range_hi;
    x  = level;
    // Reversed bounds mirror the level inside the swapped window.
    if (lo > hi) begin
      lo    = range_hi;
      hi    = range_lo;
      delta = (x >= lo) ? x - lo : 0;
      x     = (hi >= delta) ? hi - delta : 0;
    end
    if (lo == hi || x <= lo) return '0;
    q = (STRENGTH_MAX * (x - lo)) / (hi - lo);
    if (q > STRENGTH_MAX) q = STRENGTH_MAX;
    return q[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] clip_level(int x);
    if (x < 0) return '0;
    if (x > 1023) return 10'd1023;
    return x[VALUE_W-1:0];
  endfunction

  task automatic track_sample(logic [VALUE_W-1:0] value, logic [SOURCE_W-1:0] source,
                              logic bypass);
    logic [VALUE_W-1:0] level;
    if (source != active_src) return;
    if (bypass) begin
      level = value;
    end else begin
      avg_sum            = avg_sum + value - avg_ring[avg_slot];
      avg_ring[avg_slot] = value;
      avg_slot           = avg_slot + 1'b1;
      level              = avg_sum[13:4];
    end
    expected_strength.push_back(scale_strength(level));
  endtask

  task automatic send_sample(logic [VALUE_W-1:0] value, logic [SOURCE_W-1:0] source,
                             logic bypass);
    samples_if.valid         <= 1'b1;
    samples_if.sample_value  <= value;
    samples_if.sample_source <= source;
    samples_if.prefiltered   <= bypass;
    do @(posedge clk); while (samples_if.ready !== 1'b1);
    track_sample(value, source, bypass);
    if (pacing_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        samples_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Drains every outstanding result, then gives a dropped beat time to clear.
  task automatic settle();
    samples_if.valid <= 1'b0;
    while (expected_strength.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [SOURCE_W-1:0] source, logic [VALUE_W-1:0] lo,
                           logic [VALUE_W-1:0] hi);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= rssi_avs_pkg::REG_ACTIVE_SOURCE;
    cfg_data  <= {7'd0, source};
    @(posedge clk);
    active_src = source;
    cfg_index <= rssi_avs_pkg::REG_RANGE_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    range_lo = lo;
    cfg_index <= rssi_avs_pkg::REG_RANGE_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    range_hi = hi;
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_sample(10'd1023, SRC_NONE, 1'b0);
    send_sample(10'd0, SRC_NONE, 1'b0);
    send_sample(10'd1023, SRC_NONE, 1'b1);
    send_sample(10'd700, SRC_ADC, 1'b1);
  endtask

  task automatic test_source_select();
    logic [SOURCE_W-1:0] code;
    configure(SRC_RX_CHANNEL, 10'd0, 10'd1023);
    for (int i = 0; i < 8; i++) begin
      code = i[SOURCE_W-1:0];
      send_sample(10'd600, code, 1'b1);
    end
    configure(SRC_MSP, 10'd0, 10'd1023);
    send_sample(10'd512, SRC_MSP, 1'b0);
  endtask

  task automatic test_bounds();
    configure(SRC_PROTOCOL, 10'd500, 10'd500);
    send_sample(10'd500, SRC_PROTOCOL, 1'b1);
    send_sample(10'd1023, SRC_PROTOCOL, 1'b1);
    configure(SRC_PROTOCOL, 10'd100, 10'd900);
    send_sample(10'd50, SRC_PROTOCOL, 1'b1);
    send_sample(10'd100, SRC_PROTOCOL, 1'b1);
    send_sample(10'd500, SRC_PROTOCOL, 1'b1);
    send_sample(10'd900, SRC_PROTOCOL, 1'b1);
    send_sample(10'd1000, SRC_PROTOCOL, 1'b1);
    configure(SRC_ADC, 10'd900, 10'd100);
    send_sample(10'd50, SRC_ADC, 1'b1);
    send_sample(10'd500, SRC_ADC, 1'b1);
    send_sample(10'd950, SRC_ADC, 1'b1);
    configure(SRC_ADC, 10'd1023, 10'd0);
    send_sample(10'd0, SRC_ADC, 1'b1);
    send_sample(10'd1023, SRC_ADC, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [VALUE_W-1:0]  lo, hi, value;
    logic [SOURCE_W-1:0] source;
    int                  center;
    int                  pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin lo = 10'd0; hi = 10'd1023; end
        1: begin lo = 10'd1023; hi = 10'd0; end
        2: begin lo = VALUE_W'($urandom_range(0, 1023)); hi = lo; end
        3: begin lo = 10'd1023; hi = 10'd1023; end
        default: begin
          lo = VALUE_W'($urandom_range(0, 1023));
          hi = VALUE_W'($urandom_range(0, 1023));
        end
      endcase
      configure(SOURCE_W'($urandom_range(0, 4)), lo, hi);
      pacing_on = (phase % 3 != 2);
      center    = int'($urandom_range(0, 1023));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = int'($urandom_range(0, 9));
        if (pick < 4) begin
          value = VALUE_W'($urandom_range(0, 1023));
        end else if (pick < 7) begin
          case ($urandom_range(0, 3))
            0: value = clip_level(int'(lo) + int'($urandom_range(0, 8)) - 4);
            1: value = clip_level(int'(hi) + int'($urandom_range(0, 8)) - 4);
            2: value = VALUE_W'($urandom_range(0, 4));
            default: value = VALUE_W'($urandom_range(1019, 1023));
          endcase
        end else begin
          value = clip_level(center + int'($urandom_range(0, 64)) - 32);
        end
        source = ($urandom_range(0, 99) < 85) ? active_src
                                               : SOURCE_W'($urandom_range(0, 7));
        send_sample(value, source, $urandom_range(0, 3) == 0);
      end
    end
    pacing_on = 1'b1;
  endtask

  // Result side: stalls follow a pattern that is redrawn each time rx_cycle wraps.
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [7:0]  rx_cycle      = '0;

  always @(posedge clk) begin
    logic [VALUE_W-1:0] want;
    rx_cycle         <= rx_cycle + 1'b1;
    result_if.ready  <= stall_pattern[rx_cycle[3:0]];
    // Every pattern keeps bit zero set, so ready still comes up in each pass through the pattern.
    if (rx_cycle == 8'hFF) begin
      case ($urandom_range(0, 3))
        0: stall_pattern <= 16'hFFFF;
        1: stall_pattern <= 16'($urandom) | 16'h0001;
        2: stall_pattern <= 16'($urandom | $urandom) | 16'h0001;
        default: stall_pattern <= 16'($urandom & $urandom) | 16'h0001;
      endcase
    end
    if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (expected_strength.size() == 0) begin
        $error("strength: no result expected, actual %0d", result_if.strength);
        error_count++;
      end else begin
        want = expected_strength.pop_front();
        if (result_if.strength !== want) begin
          $error("strength mismatch: expected %0d, actual %0d", want, result_if.strength);
          error_count++;
        end
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((samples_if.valid === 1'b1 && samples_if.ready === 1'b1) ||
        (result_if.valid === 1'b1 && result_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("rssi_average_and_scale_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) avg_ring[i] = '0;
    rst                      <= 1'b1;
    cfg_we                   <= 1'b0;
    cfg_index                <= rssi_avs_pkg::REG_ACTIVE_SOURCE;
    cfg_data                 <= '0;
    samples_if.valid         <= 1'b0;
    samples_if.sample_value  <= '0;
    samples_if.sample_source <= '0;
    samples_if.prefiltered   <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_source_select();
    test_bounds();
    test_random_traffic();

    settle();
    if (expected_strength.size() != 0) begin
      $error("strength: %0d results never arrived", expected_strength.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("rssi_average_and_scale_test: done, clean");
    end else begin
      $display("rssi_average_and_scale_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rssi_avs_pkg.sv
hw/rtl/rssi_avs_in_if.sv
hw/rtl/rssi_avs_out_if.sv
hw/rtl/rssi_avs_ram.sv
hw/rtl/rssi_avs_div.sv
hw/rtl/rssi_average_and_scale.sv
verif/rssi_average_and_scale_test.sv
